// ----- design/yuvrgb_pkg.sv -----
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter package
// Shared types, register map and reset values of the converter.
// ---------------------------------------------------------------------------
package yuvrgb_pkg;

  // Register map: word index taken from paddr[4:2].
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_W  = 16;

  localparam logic [2:0] REG_BLUE_U_GAIN  = 3'd0;
  localparam logic [2:0] REG_GREEN_U_GAIN = 3'd1;
  localparam logic [2:0] REG_GREEN_V_GAIN = 3'd2;
  localparam logic [2:0] REG_RED_V_GAIN   = 3'd3;
  localparam logic [2:0] REG_BLUE_BIAS    = 3'd4;
  localparam logic [2:0] REG_GREEN_BIAS   = 3'd5;
  localparam logic [2:0] REG_RED_BIAS     = 3'd6;
  localparam logic [2:0] REG_LUMA_GAIN    = 3'd7;

  // BT.601 defaults loaded at reset.
  localparam logic signed [15:0] RST_BLUE_U_GAIN  = -16'sd128;
  localparam logic signed [15:0] RST_GREEN_U_GAIN = 16'sd25;
  localparam logic signed [15:0] RST_GREEN_V_GAIN = 16'sd52;
  localparam logic signed [15:0] RST_RED_V_GAIN   = -16'sd102;
  localparam logic signed [15:0] RST_BLUE_BIAS    = -16'sd17544;
  localparam logic signed [15:0] RST_GREEN_BIAS   = 16'sd8696;
  localparam logic signed [15:0] RST_RED_BIAS     = -16'sd14216;
  localparam logic [15:0]        RST_LUMA_GAIN    = 16'd18997;

  // Width of a chroma product (9-bit signed sample times 16-bit gain).
  localparam int unsigned PROD_W = 25;
  // Width of a channel sum before the shift; holds every reachable value.
  localparam int unsigned SUM_W  = 28;
  // Right shift applied to each channel sum.
  localparam int unsigned FRAC_W = 6;

  // Coefficient register file contents.
  typedef struct packed {
    logic signed [15:0] blue_u_gain;
    logic signed [15:0] green_u_gain;
    logic signed [15:0] green_v_gain;
    logic signed [15:0] red_v_gain;
    logic signed [15:0] blue_bias;
    logic signed [15:0] green_bias;
    logic signed [15:0] red_bias;
    logic [15:0]        luma_gain;
  } cfg_t;

  // Registered chroma products shared by both lanes.
  typedef struct packed {
    logic signed [PROD_W-1:0] blue_u;
    logic signed [PROD_W-1:0] green_u;
    logic signed [PROD_W-1:0] green_v;
    logic signed [PROD_W-1:0] red_v;
  } chroma_prod_t;

  // One converted pixel.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

// ----- design/yuvrgb_cfg.sv -----
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB coefficient registers
// APB-style register file holding the eight conversion coefficients.
// ---------------------------------------------------------------------------
module yuvrgb_cfg import yuvrgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [15:0] wr_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign wr_data = pwdata[REG_W-1:0];

  // Register writes on the access phase of the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blue_u_gain  <= RST_BLUE_U_GAIN;
      cfg_q.green_u_gain <= RST_GREEN_U_GAIN;
      cfg_q.green_v_gain <= RST_GREEN_V_GAIN;
      cfg_q.red_v_gain   <= RST_RED_V_GAIN;
      cfg_q.blue_bias    <= RST_BLUE_BIAS;
      cfg_q.green_bias   <= RST_GREEN_BIAS;
      cfg_q.red_bias     <= RST_RED_BIAS;
      cfg_q.luma_gain    <= RST_LUMA_GAIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLUE_U_GAIN:  cfg_q.blue_u_gain  <= wr_data;
        REG_GREEN_U_GAIN: cfg_q.green_u_gain <= wr_data;
        REG_GREEN_V_GAIN: cfg_q.green_v_gain <= wr_data;
        REG_RED_V_GAIN:   cfg_q.red_v_gain   <= wr_data;
        REG_BLUE_BIAS:    cfg_q.blue_bias    <= wr_data;
        REG_GREEN_BIAS:   cfg_q.green_bias   <= wr_data;
        REG_RED_BIAS:     cfg_q.red_bias     <= wr_data;
        REG_LUMA_GAIN:    cfg_q.luma_gain    <= wr_data;
        default:          cfg_q.luma_gain    <= cfg_q.luma_gain;
      endcase
    end
  end

  // Read-back mux; values are returned zero-extended.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BLUE_U_GAIN:  prdata[REG_W-1:0] = cfg_q.blue_u_gain;
      REG_GREEN_U_GAIN: prdata[REG_W-1:0] = cfg_q.green_u_gain;
      REG_GREEN_V_GAIN: prdata[REG_W-1:0] = cfg_q.green_v_gain;
      REG_RED_V_GAIN:   prdata[REG_W-1:0] = cfg_q.red_v_gain;
      REG_BLUE_BIAS:    prdata[REG_W-1:0] = cfg_q.blue_bias;
      REG_GREEN_BIAS:   prdata[REG_W-1:0] = cfg_q.green_bias;
      REG_RED_BIAS:     prdata[REG_W-1:0] = cfg_q.red_bias;
      REG_LUMA_GAIN:    prdata[REG_W-1:0] = cfg_q.luma_gain;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/yuvrgb_chroma.sv -----
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB chroma multipliers
// Forms the four chroma products once per word for use by both lanes.
// ---------------------------------------------------------------------------
module yuvrgb_chroma import yuvrgb_pkg::*; (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic [7:0]   chroma_u_i,
  input  logic [7:0]   chroma_v_i,
  input  cfg_t         cfg_i,
  output chroma_prod_t prod_o
);

  chroma_prod_t      prod_d;
  chroma_prod_t      prod_q;
  logic signed [8:0] u_s;
  logic signed [8:0] v_s;

  // Samples are unsigned; a zero sign bit keeps the products exact.
  assign u_s = signed'({1'b0, chroma_u_i});
  assign v_s = signed'({1'b0, chroma_v_i});

  always_comb begin
    prod_d.blue_u  = PROD_W'(u_s * cfg_i.blue_u_gain);
    prod_d.green_u = PROD_W'(u_s * cfg_i.green_u_gain);
    prod_d.green_v = PROD_W'(v_s * cfg_i.green_v_gain);
    prod_d.red_v   = PROD_W'(v_s * cfg_i.red_v_gain);
  end

  // Product register, loaded as a word enters the first stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- design/yuvrgb_lane.sv -----
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB pixel lane
// Scales one luma sample, then forms, shifts and clamps the three channels.
// ---------------------------------------------------------------------------
module yuvrgb_lane import yuvrgb_pkg::*; (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic [7:0]   luma_i,
  input  cfg_t         cfg_i,
  input  chroma_prod_t prod_i,
  output pixel_t       pixel_o
);

  logic [31:0]      luma_prod;
  logic [15:0]      luma_d;
  logic [15:0]      luma_q;
  logic [SUM_W-1:0] blue_sum;
  logic [SUM_W-1:0] green_sum;
  logic [SUM_W-1:0] red_sum;

  // Shift right and clamp to 0..255; a negative sum gives zero.
  function automatic logic [7:0] shift_clamp(input logic [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:FRAC_W+8]) begin
      res = 8'hff;
    end else begin
      res = sum[FRAC_W+7:FRAC_W];
    end
    return res;
  endfunction

  // Luma times 0x0101 is the byte repeated; one 16 by 16 multiply remains.
  assign luma_prod = {luma_i, luma_i} * cfg_i.luma_gain;
  assign luma_d    = luma_prod[31:16];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      luma_q <= luma_d;
    end
  end

  // Channel sums in two's complement; the width covers every case.
  always_comb begin
    blue_sum  = SUM_W'(cfg_i.blue_bias) + SUM_W'(luma_q) - SUM_W'(prod_i.blue_u);
    green_sum = SUM_W'(cfg_i.green_bias) + SUM_W'(luma_q)
              - SUM_W'(prod_i.green_u) - SUM_W'(prod_i.green_v);
    red_sum   = SUM_W'(cfg_i.red_bias) + SUM_W'(luma_q) - SUM_W'(prod_i.red_v);
  end

  assign pixel_o.blue  = shift_clamp(blue_sum);
  assign pixel_o.green = shift_clamp(green_sum);
  assign pixel_o.red   = shift_clamp(red_sum);

endmodule

// ----- design/yuv422_to_rgb_converter_core.sv -----
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter core
// Converts one macropixel (two luma, shared U and V) into two BGR pixels.
//
//   Port group  Direction  Handshake               Contents
//   in_*        input      in_valid_i/in_stall_o   luma pair, U, V, tail flag
//   out_*       output     out_valid_o/out_stall_i two BGR pixels, second valid
//   APB         input      psel/penable/pwrite     eight coefficient registers
//
// One word is accepted per clock while in_stall_o is low; an accepted word is
// registered in the first stage and then in the output registers.
// There are two stages, the multipliers and then sum and clamp.
// Reset empties the pipeline and loads the BT.601 coefficients.
// A stalled output holds its word; the first stage keeps accepting until full.
// ---------------------------------------------------------------------------
module yuv422_to_rgb_converter_core import yuvrgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        luma_first_i,
  input  logic [7:0]        chroma_u_i,
  input  logic [7:0]        luma_second_i,
  input  logic [7:0]        chroma_v_i,
  input  logic              single_tail_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        blue_first_o,
  output logic [7:0]        green_first_o,
  output logic [7:0]        red_first_o,
  output logic [7:0]        blue_second_o,
  output logic [7:0]        green_second_o,
  output logic [7:0]        red_second_o,
  output logic              second_valid_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t         cfg;
  chroma_prod_t prod;
  pixel_t       pix_first;
  pixel_t       pix_second;

  logic   s1_valid_q, s1_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   tail_q;
  logic   s1_ready, s2_ready, s1_load, s2_load;
  pixel_t first_q, second_q;
  logic   second_valid_q;

  // Pipeline flow control.
  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_load  = in_valid_i && s1_ready;
  assign s2_load  = s1_valid_q && s2_ready;

  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Coefficient registers.
  yuvrgb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared chroma products.
  yuvrgb_chroma u_chroma (
    .clk_i      (clk_i),
    .load_i     (s1_load),
    .chroma_u_i (chroma_u_i),
    .chroma_v_i (chroma_v_i),
    .cfg_i      (cfg),
    .prod_o     (prod)
  );

  // One lane per pixel of the macropixel.
  yuvrgb_lane u_lane_first (
    .clk_i   (clk_i),
    .load_i  (s1_load),
    .luma_i  (luma_first_i),
    .cfg_i   (cfg),
    .prod_i  (prod),
    .pixel_o (pix_first)
  );

  yuvrgb_lane u_lane_second (
    .clk_i   (clk_i),
    .load_i  (s1_load),
    .luma_i  (luma_second_i),
    .cfg_i   (cfg),
    .prod_i  (prod),
    .pixel_o (pix_second)
  );

  // Tail flag travels alongside the first stage.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      tail_q <= single_tail_i;
    end
  end

  // Merge the lanes into the output word; an odd tail blanks the second pixel.
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      first_q        <= pix_first;
      second_q       <= tail_q ? '0 : pix_second;
      second_valid_q <= !tail_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_first_o   = first_q.blue;
  assign green_first_o  = first_q.green;
  assign red_first_o    = first_q.red;
  assign blue_second_o  = second_q.blue;
  assign green_second_o = second_q.green;
  assign red_second_o   = second_q.red;
  assign second_valid_o = second_valid_q;

  // An accepted word always occupies the first stage in the next cycle.
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted word did not reach the first stage");

  // A word in the first stage moves on whenever the output can take it.
  a_s1_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (!out_valid_o || !out_stall_i)) |=> out_valid_o)
    else $error("first stage word was lost");

  // Input stalls only when both stages hold words and the output is blocked.
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // An odd tail word carries a blank second pixel.
  a_tail_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !second_valid_o) |->
      (blue_second_o == 8'd0 && green_second_o == 8'd0 && red_second_o == 8'd0))
    else $error("tail word has a non-zero second pixel");

endmodule
